[src/bfdh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter package
// Shared types and constants for the double-hash Bloom filter.
// ----------------------------------------------------------------------------
package bfdh_pkg;

  localparam int unsigned DEF_MAX_BITS = 65536;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned SIZE_W       = 17;
  localparam int unsigned NH_W         = 8;
  localparam int unsigned HASH_W       = 64;
  localparam int unsigned CNT_W        = 17;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES  = 8'd1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_READ, ST_WAIT, ST_UPDATE, ST_NEXT, ST_DONE
  } bfdh_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clr_wr;    // write zero at clear address
    logic load;      // capture new item
    logic mod_start; // begin probe index reduction
    logic mem_rd;    // issue array read at probe index
    logic update;    // evaluate read bit (set or test)
    logic advance;   // next probe
  } bfdh_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic probes_done; // no probe left
    logic miss;        // check found a clear bit
  } bfdh_sts_t;

endpackage

[src/bfdh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module bfdh_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

[src/bfdh_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring modulo unit
// Reduces a 64-bit value modulo a 17-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bfdh_mod
  import bfdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [SIZE_W-1:0] remainder
);
  localparam int unsigned BIT_CNT_W = $clog2(HASH_W);

  logic [HASH_W-1:0]    dvd_r, dvd_nxt;
  logic [SIZE_W:0]      rem_r, rem_nxt;
  logic [BIT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [SIZE_W:0]      shifted;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[SIZE_W-1:0], dvd_r[HASH_W-1]};
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[HASH_W-2:0], 1'b0};
      if (shifted >= {1'b0, divisor}) begin
        rem_nxt = shifted - {1'b0, divisor};
      end else begin
        rem_nxt = shifted;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == BIT_CNT_W'(HASH_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[SIZE_W-1:0];
endmodule

[src/bfdh_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter controller
// Sequences the clearing pass and the probes of each item.
// ----------------------------------------------------------------------------
module bfdh_ctrl
  import bfdh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic        out_free,
  input  bfdh_sts_t   sts,
  output bfdh_cmd_t   cmd,
  output logic        in_ready,
  output logic        out_load
);
  bfdh_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (sts.probes_done || sts.miss) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mod_start = 1'b1;
          state_nxt     = ST_MOD;
        end
      end
      ST_MOD: begin
        if (sts.mod_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update  = 1'b1;
        cmd.advance = 1'b1;
        state_nxt   = ST_NEXT;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

[src/bfdh_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter datapath
// Probe arithmetic, bit array, set-bit count and configuration registers.
// ----------------------------------------------------------------------------
module bfdh_dp
  import bfdh_pkg::*;
#(
  parameter int unsigned MAX_BITS = DEF_MAX_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bfdh_cmd_t            cmd,
  output bfdh_sts_t            sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]          cfg_val,
  input  logic                 op_in,
  input  logic [HASH_W-1:0]    h0_in,
  input  logic [HASH_W-1:0]    h1_in,
  output logic                 present,
  output logic [CNT_W-1:0]     bits_set
);
  localparam int unsigned AW = $clog2(MAX_BITS);
  localparam int unsigned CW = $clog2(MAX_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  logic [SIZE_W-1:0] fbits_r;
  logic [NH_W-1:0]   nh_r;
  logic              op_r;
  logic [HASH_W-1:0] acc_r, step_r;
  logic [NH_W-1:0]   left_r;
  logic              miss_r;
  logic [CW-1:0]     cnt_r;
  logic [AW-1:0]     clr_addr_r;
  logic [SIZE_W-1:0] rem;
  logic              mod_done;
  logic              rd_bit;
  logic [SIZE_W-1:0] n_eff;
  logic [AW-1:0]     probe_idx;
  logic              set_now;

  // Effective size: zero counts as one, saturated at the array size.
  always_comb begin
    if (fbits_r == '0) begin
      n_eff = SIZE_W'(1);
    end else if (32'(fbits_r) > MAX_BITS) begin
      n_eff = SIZE_W'(MAX_BITS);
    end else begin
      n_eff = fbits_r;
    end
  end

  bfdh_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (acc_r),
    .divisor  (n_eff),
    .done     (mod_done),
    .remainder(rem)
  );

  assign probe_idx = AW'(rem);
  assign set_now   = cmd.update && (op_r == OP_INSERT) && !rd_bit;

  bfdh_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_ram (
    .clk    (clk),
    .wr_en  (cmd.clr_wr || set_now),
    .wr_addr(cmd.clr_wr ? clr_addr_r : probe_idx),
    .wr_data(!cmd.clr_wr),
    .rd_en  (cmd.mem_rd),
    .rd_addr(probe_idx),
    .rd_data(rd_bit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbits_r    <= SIZE_W'(65536);
      nh_r       <= NH_W'(4);
      cnt_r      <= '0;
      clr_addr_r <= '0;
      miss_r     <= 1'b0;
      left_r     <= '0;
    end else begin
      if (cfg_we && cfg_idx == REG_FILTER_BITS) fbits_r <= cfg_val[SIZE_W-1:0];
      if (cfg_we && cfg_idx == REG_NUM_HASHES)  nh_r    <= cfg_val[NH_W-1:0];
      if (cmd.clr_wr) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.load) begin
        left_r <= nh_r;
        miss_r <= 1'b0;
      end
      if (cmd.advance) left_r <= left_r - 1'b1;
      if (cmd.update && op_r == OP_CHECK && !rd_bit) miss_r <= 1'b1;
      if (set_now) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_in;
      acc_r  <= h0_in;
      step_r <= h1_in;
    end else if (cmd.advance) begin
      acc_r <= acc_r + step_r;
    end
  end

  assign sts.clr_last    = (clr_addr_r == AW'(MAX_BITS - 1));
  assign sts.mod_done    = mod_done;
  assign sts.probes_done = (left_r == '0);
  assign sts.miss        = miss_r;

  assign present  = (op_r == OP_CHECK) && !miss_r;
  assign bits_set = (CW > CNT_W && 32'(cnt_r) > 32'(CNT_SAT)) ? CNT_SAT : CNT_W'(cnt_r);
endmodule

[src/bloom_filter_double_hash.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter with double hashing
// Inserts or checks keys given by two 64-bit hash halves in a bit array.
// ----------------------------------------------------------------------------
// An item's probes run one after another between the input transfer and out_tvalid; a
// check stops at its first clear bit, and an item with zero probes goes straight to output.
// Throughput: one item at a time, a new item only once the last result is loaded;
// the 64-step modulo unit sets the probe time.
// Reset: after rst_n the array is swept clear, one bit a cycle, until all MAX_BITS
// bits are cleared; no item is taken then, while configuration writes are accepted.
module bloom_filter_double_hash
  import bfdh_pkg::*;
#(
  parameter int unsigned MAX_BITS = DEF_MAX_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [135:0]         in_tdata,  // opcode[0], hash_low[64:1], hash_high[128:65]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata, // present[0], bits_set[17:1]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);
  bfdh_cmd_t        cmd;
  bfdh_sts_t        sts;
  logic             in_fire;
  logic             out_load;
  logic             present;
  logic [CNT_W-1:0] bits_set;
  logic             out_valid_r;
  logic [23:0]      out_data_r;

  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  bfdh_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .out_free(!out_valid_r || out_tready),
    .sts     (sts),
    .cmd     (cmd),
    .in_ready(in_tready),
    .out_load(out_load)
  );

  bfdh_dp #(.MAX_BITS(MAX_BITS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_idx (cfg_index),
    .cfg_val (cfg_data),
    .op_in   (in_tdata[0]),
    .h0_in   (in_tdata[64:1]),
    .h1_in   (in_tdata[128:65]),
    .present (present),
    .bits_set(bits_set)
  );

  // Output register: the result waits here while the next item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= {6'd0, bits_set, present};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A result is loaded only when the register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready)) else $error("result overwritten");

  // No item is taken while a modulo is under way.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mod_start |=> !in_tready) else $error("accept during probe");

  // The set-bit count never falls.
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && $past(rst_n) |-> bits_set >= $past(bits_set)) else $error("count fell");
endmodule
